### rtl/mto_pkg.sv
// Shared types, constants and step codes for the modulated triangle oscillator.
package mto_pkg;

   // Default sine table length (entries over one turn)
   localparam int SINE_TABLE_DEPTH_DEF = 256;

   // Secondary LFO frequency, Q0.16 Hz
   localparam logic [15:0] SUB_LFO_FREQ = 16'd66;
   // LFO depth applied to the rotation rate, Q4.8 rad/s
   localparam logic [11:0] ROT_MOD_DEPTH = 12'd0;
   // 65536 / (2*pi) in Q14.16
   localparam logic [29:0] RAD_TO_BAM = 30'd683565276;

   // Shared multiplier shape
   localparam int MUL_W = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Rate limits in Q8.16
   localparam logic signed [23:0] N_RATE_MAX = 24'sd1310720;
   localparam logic signed [23:0] ROT_RATE_MAX = 24'sd393216;
   localparam logic signed [23:0] ROT_RATE_MIN = -24'sd393216;

   // Register indexes
   localparam logic [2:0] CSR_CONTROL_MODE = 3'd0;
   localparam logic [2:0] CSR_N_MIN = 3'd1;
   localparam logic [2:0] CSR_N_MAX = 3'd2;
   localparam logic [2:0] CSR_N_SPEED = 3'd3;
   localparam logic [2:0] CSR_N_MOD_DEPTH = 3'd4;
   localparam logic [2:0] CSR_ROT_SPEED = 3'd5;
   localparam logic [2:0] CSR_LFO_FREQ = 3'd6;
   localparam logic [2:0] CSR_SUB_LFO_AMP = 3'd7;

   // Secondary modulation targets (control_mode bits 2:1)
   localparam logic [1:0] SEC_FREQ = 2'd0;
   localparam logic [1:0] SEC_AMP = 2'd1;

   // Datapath step codes
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_M_PH2,
      OP_W_PH,
      OP_M_IDX,
      OP_W_ROM,
      OP_M_SUB,
      OP_W_SUB,
      OP_M_PH1,
      OP_M_NAMP,
      OP_W_NRATE,
      OP_M_STEP,
      OP_W_N,
      OP_M_RAMP,
      OP_W_RRATE,
      OP_W_RAD,
      OP_M_RINC,
      OP_W_ANG,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

endpackage

### rtl/mto_ctrl.sv
// Step sequencer for the modulated triangle oscillator.
module mto_ctrl
   import mto_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_hold,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_M_PH2, S_W_PH2, S_M_IDX2, S_W_ROM2, S_M_SUB, S_W_SUB,
      S_M_PH1, S_W_PH1, S_M_IDX1, S_W_ROM1, S_M_NAMP, S_W_NRATE,
      S_M_NSTEP, S_W_N, S_M_RAMP, S_W_RRATE, S_M_RSTEP, S_W_RAD,
      S_M_RINC, S_W_ANG, S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // result slot is free when empty or being taken now
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // step code for the datapath
   always_comb begin
      unique case (state_ff)
         S_IDLE:     cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
         S_M_PH2:    cmd.op = OP_M_PH2;
         S_W_PH2:    cmd.op = OP_W_PH;
         S_M_IDX2:   cmd.op = OP_M_IDX;
         S_W_ROM2:   cmd.op = OP_W_ROM;
         S_M_SUB:    cmd.op = OP_M_SUB;
         S_W_SUB:    cmd.op = OP_W_SUB;
         S_M_PH1:    cmd.op = OP_M_PH1;
         S_W_PH1:    cmd.op = OP_W_PH;
         S_M_IDX1:   cmd.op = OP_M_IDX;
         S_W_ROM1:   cmd.op = OP_W_ROM;
         S_M_NAMP:   cmd.op = OP_M_NAMP;
         S_W_NRATE:  cmd.op = OP_W_NRATE;
         S_M_NSTEP:  cmd.op = OP_M_STEP;
         S_W_N:      cmd.op = OP_W_N;
         S_M_RAMP:   cmd.op = OP_M_RAMP;
         S_W_RRATE:  cmd.op = OP_W_RRATE;
         S_M_RSTEP:  cmd.op = OP_M_STEP;
         S_W_RAD:    cmd.op = OP_W_RAD;
         S_M_RINC:   cmd.op = OP_M_RINC;
         S_W_ANG:    cmd.op = OP_W_ANG;
         S_OUT:      cmd.op = out_free ? OP_OUT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces the one being taken
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= req_hold ? S_OUT : S_M_PH2;
               end
            end
            S_M_PH2:   state_ff <= S_W_PH2;
            S_W_PH2:   state_ff <= S_M_IDX2;
            S_M_IDX2:  state_ff <= S_W_ROM2;
            S_W_ROM2:  state_ff <= S_M_SUB;
            S_M_SUB:   state_ff <= S_W_SUB;
            S_W_SUB:   state_ff <= S_M_PH1;
            S_M_PH1:   state_ff <= S_W_PH1;
            S_W_PH1:   state_ff <= S_M_IDX1;
            S_M_IDX1:  state_ff <= S_W_ROM1;
            S_W_ROM1:  state_ff <= S_M_NAMP;
            S_M_NAMP:  state_ff <= S_W_NRATE;
            S_W_NRATE: state_ff <= S_M_NSTEP;
            S_M_NSTEP: state_ff <= S_W_N;
            S_W_N:     state_ff <= S_M_RAMP;
            S_M_RAMP:  state_ff <= S_W_RRATE;
            S_W_RRATE: state_ff <= S_M_RSTEP;
            S_M_RSTEP: state_ff <= S_W_RAD;
            S_W_RAD:   state_ff <= S_M_RINC;
            S_M_RINC:  state_ff <= S_W_ANG;
            S_W_ANG:   state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   // one word in flight: an accept is followed by a busy cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while a word is in progress");

   // a result appears only from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result valid raised outside the output step");

endmodule

### rtl/mto_datapath.sv
// Registers, shared multiplier and sine table of the modulated triangle oscillator.
module mto_datapath
   import mto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [15:0]       req_dt,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [14:0]       csr_wdata,
   output logic [14:0]       rsp_n_value,
   output logic [15:0]       rsp_rotation_angle,
   output logic              rsp_rising
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

   // configuration
   logic [2:0]         mode_ff;
   logic [14:0]        n_min_ff, n_max_ff;
   logic [12:0]        n_speed_ff, n_depth_ff, sub_amp_ff;
   logic signed [11:0] rot_speed_ff;
   logic [11:0]        lfo_freq_ff;

   // oscillator state
   logic [14:0] n_ff;
   logic        up_ff;
   logic [15:0] angle_ff;
   logic [31:0] time_ff;

   // work registers
   logic [15:0]               dt_ff, ph_ff;
   logic signed [15:0]        rom_q_ff;
   logic signed [17:0]        sub_ff;
   logic signed [21:0]        rate_ff;
   logic signed [27:0]        rad_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [14:0]               out_n_ff;
   logic [15:0]               out_angle_ff;
   logic                      out_rising_ff;

   // sine table, Q1.14, worked out at elaboration
   logic signed [15:0] rom_tbl [SINE_TABLE_DEPTH];
   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam longint A = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
      localparam longint U = A % 32768;
      localparam longint P = U * (32768 - U);
      localparam longint DEN = 5 * 1073741824 - 4 * P;
      localparam longint S = (P * 262144) / DEN;
      assign rom_tbl[k] = 16'((A >= 32768) ? -S : S);
   end

   // modulation terms
   logic [1:0]         sec_sel;
   logic signed [21:0] freq_q;
   logic signed [23:0] amp_term, amp_n, amp_r, base_n, base_r, mod_sum_n, mod_sum_r;
   logic signed [23:0] mod_term;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in, round_n, round_a;
   logic [13:0]        n_step;
   logic signed [16:0] n_up, n_dn, n_max_s, n_min_s;
   logic signed [21:0] n_rate_in, r_rate_in;

   assign sec_sel  = mode_ff[2:1];
   assign freq_q   = signed'({2'b00, lfo_freq_ff, 8'h00})
                     + ((sec_sel == SEC_FREQ) ? {{4{sub_ff[17]}}, sub_ff} : 22'sd0);
   assign amp_term = (sec_sel == SEC_AMP) ? {{6{sub_ff[17]}}, sub_ff} : 24'sd0;
   assign amp_n    = signed'({3'b000, n_depth_ff, 8'h00}) + amp_term;
   assign amp_r    = signed'({4'h0, ROT_MOD_DEPTH, 8'h00}) + amp_term;
   assign base_n   = signed'({3'b000, n_speed_ff, 8'h00});
   assign base_r   = {{4{rot_speed_ff[11]}}, rot_speed_ff, 8'h00};
   assign mod_term = prod_ff[37:14];
   assign mod_sum_n = base_n + mod_term;
   assign mod_sum_r = base_r + mod_term;

   // clamp of the two rates
   always_comb begin
      priority if (mod_sum_n < 24'sd0) n_rate_in = 22'sd0;
      else if (mod_sum_n > N_RATE_MAX) n_rate_in = 22'(N_RATE_MAX);
      else n_rate_in = 22'(mod_sum_n);
      priority if (mod_sum_r < ROT_RATE_MIN) r_rate_in = 22'(ROT_RATE_MIN);
      else if (mod_sum_r > ROT_RATE_MAX) r_rate_in = 22'(ROT_RATE_MAX);
      else r_rate_in = 22'(mod_sum_r);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_M_PH2: begin
            mul_a = signed'({1'b0, time_ff});
            mul_b = signed'(MUL_W'(SUB_LFO_FREQ));
         end
         OP_M_IDX: begin
            mul_a = signed'(MUL_W'(ph_ff));
            mul_b = MUL_W'(SINE_TABLE_DEPTH);
         end
         OP_M_SUB: begin
            mul_a = signed'(MUL_W'(sub_amp_ff));
            mul_b = MUL_W'(rom_q_ff);
         end
         OP_M_PH1: begin
            mul_a = signed'({1'b0, time_ff});
            mul_b = MUL_W'(freq_q);
         end
         OP_M_NAMP: begin
            mul_a = MUL_W'(amp_n);
            mul_b = MUL_W'(rom_q_ff);
         end
         OP_M_STEP: begin
            mul_a = MUL_W'(rate_ff);
            mul_b = signed'(MUL_W'(dt_ff));
         end
         OP_M_RAMP: begin
            mul_a = MUL_W'(amp_r);
            mul_b = MUL_W'(rom_q_ff);
         end
         OP_M_RINC: begin
            mul_a = MUL_W'(rad_ff);
            mul_b = signed'(MUL_W'(RAD_TO_BAM));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign round_n = prod_ff + PROD_W'(64'h80_0000);
   assign round_a = prod_ff + PROD_W'(64'h80_0000_0000);
   assign n_step  = round_n[37:24];

   // sweep candidates
   assign n_up    = signed'({2'b00, n_ff}) + signed'({3'b000, n_step});
   assign n_dn    = signed'({2'b00, n_ff}) - signed'({3'b000, n_step});
   assign n_max_s = signed'({2'b00, n_max_ff});
   assign n_min_s = signed'({2'b00, n_min_ff});

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 3'd1;
         n_min_ff     <= 15'd256;
         n_max_ff     <= 15'd2048;
         n_speed_ff   <= 13'd256;
         n_depth_ff   <= 13'd0;
         rot_speed_ff <= 12'sd0;
         lfo_freq_ff  <= 12'd256;
         sub_amp_ff   <= 13'd0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CONTROL_MODE: mode_ff      <= csr_wdata[2:0];
            CSR_N_MIN:        n_min_ff     <= csr_wdata;
            CSR_N_MAX:        n_max_ff     <= csr_wdata;
            CSR_N_SPEED:      n_speed_ff   <= csr_wdata[12:0];
            CSR_N_MOD_DEPTH:  n_depth_ff   <= csr_wdata[12:0];
            CSR_ROT_SPEED:    rot_speed_ff <= signed'(csr_wdata[11:0]);
            CSR_LFO_FREQ:     lfo_freq_ff  <= csr_wdata[11:0];
            CSR_SUB_LFO_AMP:  sub_amp_ff   <= csr_wdata[12:0];
            default:          mode_ff      <= mode_ff;
         endcase
      end
   end

   // oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= 15'd256;
         up_ff    <= 1'b1;
         angle_ff <= 16'd0;
         time_ff  <= 32'd0;
      end else begin
         if (cmd.op == OP_W_N && mode_ff[0]) begin
            if (up_ff) begin
               if (n_up >= n_max_s) begin
                  n_ff  <= n_max_ff;
                  up_ff <= 1'b0;
               end else begin
                  n_ff <= n_up[14:0];
               end
            end else begin
               if (n_dn <= n_min_s) begin
                  n_ff  <= n_min_ff;
                  up_ff <= 1'b1;
               end else begin
                  n_ff <= n_dn[14:0];
               end
            end
         end
         if (cmd.op == OP_W_ANG) begin
            angle_ff <= angle_ff + round_a[55:40];
            time_ff  <= time_ff + {16'h0000, dt_ff};
         end
      end
   end

   // work registers and result word
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         out_n_ff      <= 15'd0;
         out_angle_ff  <= 16'd0;
         out_rising_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_CAPTURE: dt_ff    <= req_dt;
            OP_W_PH:    ph_ff    <= prod_ff[31:16];
            OP_W_ROM:   rom_q_ff <= rom_tbl[prod_ff[16 +: IDX_W]];
            OP_W_SUB:   sub_ff   <= prod_ff[27:10];
            OP_W_NRATE: rate_ff  <= n_rate_in;
            OP_W_RRATE: rate_ff  <= r_rate_in;
            OP_W_RAD:   rad_ff   <= prod_ff[35:8];
            OP_OUT: begin
               out_n_ff      <= n_ff;
               out_angle_ff  <= angle_ff;
               out_rising_ff <= up_ff;
            end
            default: dt_ff <= dt_ff;
         endcase
      end
   end

   assign rsp_n_value        = out_n_ff;
   assign rsp_rotation_angle = out_angle_ff;
   assign rsp_rising         = out_rising_ff;

   // angle and LFO time move only in the angle write-back step
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(cmd.op) != OP_W_ANG) |-> ($stable(angle_ff) && $stable(time_ff)))
      else $error("angle or LFO time changed outside the final step");

   // the result word changes only at the output step
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.op) != OP_OUT) |-> ($stable(out_n_ff) && $stable(out_angle_ff)))
      else $error("result word changed outside the output step");

endmodule

### rtl/modulated_triangle_oscillator_top.sv
// Top level of the modulated triangle oscillator.
// Each accepted word advances the oscillator by dt and returns one result word with the
// updated n value, rotation angle and sweep direction; a word with hold set skips the
// update and returns the current state. Without hold, one shared 33x33 multiplier and
// the registered sine table are stepped through twenty multiply and write-back steps by
// the sequencer. A new word is taken once the previous one has moved into the result
// register, which may still wait for the receiver. Configuration writes take effect at
// once; they are to be made only while the block is idle, which it does not enforce.
module modulated_triangle_oscillator_top
   import mto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_dt,
   input  logic        req_hold,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_n_value,
   output logic [15:0] rsp_rotation_angle,
   output logic        rsp_rising,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   dp_cmd_type cmd;

   // sequencer
   mto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_hold  (req_hold),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath
   mto_datapath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_dt             (req_dt),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_n_value        (rsp_n_value),
      .rsp_rotation_angle (rsp_rotation_angle),
      .rsp_rising         (rsp_rising)
   );

endmodule
